@@ hw/rtl/lasc_pkg.sv @@
// shared constants for the light apparent size calculator
// no dependencies
package lasc_pkg;

  localparam int unsigned MaxLightsDef = 8;
  localparam int unsigned PosW  = 40;
  localparam int unsigned SizeW = 32;
  localparam int unsigned MulW  = 20;
  localparam int unsigned DivW  = 82;
  localparam int unsigned CosW  = 17;
  localparam int unsigned SolidW = 19;

  localparam logic [MulW-1:0] TwoPiQ16 = 20'd411775;
  localparam logic [CosW-1:0] CosOne   = 17'd65536;

  typedef enum logic [1:0] {
    CFG_OFFSET_X = 2'd0,
    CFG_OFFSET_Y = 2'd1,
    CFG_OFFSET_Z = 2'd2
  } cfg_idx_e;

endpackage

@@ hw/rtl/lasc_mul.sv @@
// shared 20x20 unsigned multiplier with registered product
// depends on lasc_pkg
module lasc_mul (
  input  logic                          clk_i,
  input  logic [lasc_pkg::MulW-1:0]     a_i,
  input  logic [lasc_pkg::MulW-1:0]     b_i,
  output logic [2*lasc_pkg::MulW-1:0]   p_o
);

  logic [2*lasc_pkg::MulW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ hw/rtl/lasc_sub.sv @@
// shared wide subtract and compare unit for divide and square root steps
// depends on lasc_pkg
module lasc_sub (
  input  logic [lasc_pkg::DivW-1:0] a_i,
  input  logic [lasc_pkg::DivW-1:0] b_i,
  output logic [lasc_pkg::DivW-1:0] diff_o,
  output logic                      ge_o
);

  logic [lasc_pkg::DivW:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[lasc_pkg::DivW-1:0];
  assign ge_o   = ~full[lasc_pkg::DivW];

endmodule

@@ hw/rtl/light_apparent_size_calc.sv @@
// top level of the light apparent size calculator: sequencer and datapath
// depends on lasc_pkg, lasc_mul, lasc_sub
//
// channel | direction | handshake              | payload
// in      | input     | in_valid_i/in_ready_o  | light_*, camera_*, light_size, light_on, last_light
// out     | output    | out_valid_o/out_ready_i| slot, slot_valid, on_out, half_size, cos, solid, ...
// cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// a lit light with positive half size is taken in idle, then the sequencer squares the
// axis distances and the half size on the shared 20x20 multiplier, compares, divides for a
// 32-bit quotient and takes a 16-bit square root on the shared subtractor, forms the solid
// angle product and hands over the result; a light inside its own size stops after the compare
// lights that are off or point lights go from idle straight to the result hand-over
// in_ready_o is high only while the sequencer is idle; a finished result waits in the
// output register, so a new item is taken while the old one is stalled
// reset clears offsets, slot counters and the sequencer
module light_apparent_size_calc #(
  parameter int unsigned MAX_LIGHTS = lasc_pkg::MaxLightsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [lasc_pkg::PosW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [lasc_pkg::PosW-1:0]  light_x_i,
  input  logic signed [lasc_pkg::PosW-1:0]  light_y_i,
  input  logic signed [lasc_pkg::PosW-1:0]  light_z_i,
  input  logic signed [lasc_pkg::PosW-1:0]  camera_x_i,
  input  logic signed [lasc_pkg::PosW-1:0]  camera_y_i,
  input  logic signed [lasc_pkg::PosW-1:0]  camera_z_i,
  input  logic signed [lasc_pkg::SizeW-1:0] light_size_i,
  input  logic                              light_on_i,
  input  logic                              last_light_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        slot_o,
  output logic                              slot_valid_o,
  output logic                              on_out_o,
  output logic signed [30:0]                half_size_o,
  output logic [lasc_pkg::CosW-1:0]         cos_angle_o,
  output logic [lasc_pkg::SolidW-1:0]       solid_angle_o,
  output logic [2:0]                        highest_on_o,
  output logic                              last_out_o
);

  localparam int unsigned CntW = $clog2(MAX_LIGHTS + 1);
  localparam int unsigned PW   = lasc_pkg::PosW;
  localparam int unsigned MW   = lasc_pkg::MulW;
  localparam int unsigned DW   = lasc_pkg::DivW;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SQR   = 7'b0000010,
    ST_CMP   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_SQRT  = 7'b0010000,
    ST_SOLID = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // offset registers
  logic [PW-1:0] off_x_q, off_y_q, off_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lasc_pkg::CFG_OFFSET_X: off_x_q <= cfg_data_i;
        lasc_pkg::CFG_OFFSET_Y: off_y_q <= cfg_data_i;
        lasc_pkg::CFG_OFFSET_Z: off_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated magnitude of light - camera + offset on one axis
  function automatic logic [PW-1:0] axis_abs(logic [PW-1:0] l, logic [PW-1:0] c,
                                             logic [PW-1:0] o);
    logic signed [PW+1:0] sum;
    logic signed [PW+1:0] sat;
    logic signed [PW+1:0] mag;
    sum = $signed({{2{l[PW-1]}}, l}) - $signed({{2{c[PW-1]}}, c})
        + $signed({{2{o[PW-1]}}, o});
    if (sum > $signed({3'b000, {(PW-1){1'b1}}})) begin
      sat = $signed({3'b000, {(PW-1){1'b1}}});
    end else if (sum < $signed({3'b111, {(PW-1){1'b0}}})) begin
      sat = $signed({3'b111, {(PW-1){1'b0}}});
    end else begin
      sat = sum;
    end
    mag = sat[PW+1] ? -sat : sat;
    return mag[PW-1:0];
  endfunction

  logic          accept;
  logic [PW-1:0] ax_q, ay_q, az_q, sv_q;
  logic signed [30:0] half_in;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign half_in    = light_size_i[31:1];   // arithmetic floor of size / 2

  // slot bookkeeping, settled at accept
  logic [CntW-1:0] cnt_q;
  logic [2:0]      high_q;
  logic            slot_ok;
  logic [2:0]      r_slot_q, r_high_q;
  logic            r_valid_q, r_on_q, r_last_q;
  logic signed [30:0] r_half_q;

  assign slot_ok = cnt_q < CntW'(MAX_LIGHTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      high_q <= '0;
    end else if (accept) begin
      if (last_light_i) begin
        cnt_q  <= '0;
        high_q <= '0;
      end else begin
        if (slot_ok) cnt_q <= cnt_q + 1'b1;
        if (slot_ok && light_on_i) high_q <= 3'(cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_slot_q  <= slot_ok ? 3'(cnt_q) : 3'd0;
      r_valid_q <= slot_ok;
      r_on_q    <= slot_ok && light_on_i;
      r_high_q  <= (slot_ok && light_on_i) ? 3'(cnt_q) : high_q;
      r_last_q  <= last_light_i;
      r_half_q  <= light_on_i ? half_in : '0;
      ax_q      <= axis_abs(light_x_i, camera_x_i, off_x_q);
      ay_q      <= axis_abs(light_y_i, camera_y_i, off_y_q);
      az_q      <= axis_abs(light_z_i, camera_z_i, off_z_q);
      sv_q      <= PW'(unsigned'(half_in[29:0]));
    end
  end

  // shared multiplier
  logic [1:0]      vsel_q, psel_q;
  logic [PW-1:0]   mval;
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] prod;
  logic            acc_en_q, acc_s_q;
  logic [1:0]      acc_p_q;
  logic [3:0]      sq_cnt_q;
  logic            ph_q;

  always_comb begin
    case (vsel_q)
      2'd0:    mval = ax_q;
      2'd1:    mval = ay_q;
      2'd2:    mval = az_q;
      default: mval = sv_q;
    endcase
  end

  logic [lasc_pkg::CosW-1:0] cos_q;
  logic [lasc_pkg::CosW-1:0] cos_rest;
  assign cos_rest = lasc_pkg::CosOne - cos_q;

  always_comb begin
    if (state_q == ST_SOLID) begin
      mul_a = lasc_pkg::TwoPiQ16;
      mul_b = MW'(cos_rest);
    end else begin
      case (psel_q)
        2'd0:    begin mul_a = mval[MW-1:0];  mul_b = mval[MW-1:0];  end
        2'd1:    begin mul_a = mval[MW-1:0];  mul_b = mval[PW-1:MW]; end
        default: begin mul_a = mval[PW-1:MW]; mul_b = mval[PW-1:MW]; end
      endcase
    end
  end

  lasc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // partial products land at bit 0, 21 (cross term doubled) or 40
  logic [2*PW-1:0] prod_sh;
  always_comb begin
    case (acc_p_q)
      2'd0:    prod_sh = {{(2*PW-2*MW){1'b0}}, prod};
      2'd1:    prod_sh = {{(2*PW-2*MW){1'b0}}, prod} << (MW + 1);
      default: prod_sh = {{(2*PW-2*MW){1'b0}}, prod} << (2 * MW);
    endcase
  end

  // shared subtractor
  logic [2*PW-1:0] d2_q, s2_q;
  logic [2*PW:0]   rem_q;
  logic [2*PW:0]   den_q;
  logic [31:0]     q_q, qs_q;
  logic [17:0]     srem_q;
  logic [15:0]     root_q;
  logic [5:0]      it_q;
  logic [DW-1:0]   sub_a, sub_b, sub_diff;
  logic            sub_ge;
  logic [lasc_pkg::SolidW-1:0] solid_q;

  always_comb begin
    case (state_q)
      ST_CMP:  begin sub_a = DW'(s2_q); sub_b = DW'(d2_q); end
      ST_DIV:  begin sub_a = {rem_q, 1'b0}; sub_b = DW'(den_q); end
      ST_SQRT: begin
        sub_a = DW'({srem_q, qs_q[31:30]});
        sub_b = DW'({root_q, 2'b01});
      end
      default: begin sub_a = '0; sub_b = '0; end
    endcase
  end

  lasc_sub u_sub (
    .a_i    (sub_a),
    .b_i    (sub_b),
    .diff_o (sub_diff),
    .ge_o   (sub_ge)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!light_on_i || half_in <= 0) state_d = ST_DONE;
          else state_d = ST_SQR;
        end
      end
      ST_SQR:   if (sq_cnt_q == 4'd12) state_d = ST_CMP;
      ST_CMP:   state_d = sub_ge ? ST_DONE : ST_DIV;
      ST_DIV:   if (it_q == 6'd31) state_d = ST_SQRT;
      ST_SQRT:  if (it_q == 6'd15) state_d = ST_SOLID;
      ST_SOLID: if (ph_q) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_o || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // sequencer counters and arithmetic registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
      vsel_q   <= '0;
      psel_q   <= '0;
      acc_en_q <= 1'b0;
      it_q     <= '0;
      ph_q     <= 1'b0;
    end else begin
      acc_en_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          sq_cnt_q <= '0;
          vsel_q   <= '0;
          psel_q   <= '0;
          it_q     <= '0;
          ph_q     <= 1'b0;
        end
        ST_SQR: begin
          sq_cnt_q <= sq_cnt_q + 1'b1;
          acc_en_q <= (sq_cnt_q != 4'd12);
          if (psel_q == 2'd2) begin
            psel_q <= '0;
            vsel_q <= vsel_q + 1'b1;
          end else begin
            psel_q <= psel_q + 1'b1;
          end
        end
        ST_CMP:  it_q <= '0;
        ST_DIV:  it_q <= (it_q == 6'd31) ? 6'd0 : it_q + 1'b1;
        ST_SQRT: it_q <= it_q + 1'b1;
        ST_SOLID: ph_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_s_q <= (vsel_q == 2'd3);
    acc_p_q <= psel_q;
    case (state_q)
      ST_IDLE: begin
        d2_q <= '0;
        s2_q <= '0;
        if (accept) begin
          // point light starts at full cosine, off light at zero
          cos_q   <= (light_on_i && half_in <= 0) ? lasc_pkg::CosOne : '0;
          solid_q <= '0;
        end
      end
      ST_SQR: begin
        if (acc_en_q) begin
          if (acc_s_q) s2_q <= s2_q + prod_sh;
          else         d2_q <= d2_q + prod_sh;
        end
      end
      ST_CMP: begin
        // light inside its own size when s^2 >= d^2
        cos_q   <= '0;
        solid_q <= lasc_pkg::SolidW'(lasc_pkg::TwoPiQ16);
        rem_q   <= {1'b0, d2_q};
        den_q   <= {1'b0, d2_q} + {1'b0, s2_q};
        q_q     <= '0;
      end
      ST_DIV: begin
        rem_q <= sub_ge ? sub_diff[2*PW:0] : {rem_q[2*PW-1:0], 1'b0};
        q_q   <= {q_q[30:0], sub_ge};
        if (it_q == 6'd31) begin
          qs_q   <= {q_q[30:0], sub_ge};
          srem_q <= '0;
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        srem_q <= sub_ge ? sub_diff[17:0] : {srem_q[15:0], qs_q[31:30]};
        root_q <= {root_q[14:0], sub_ge};
        qs_q   <= {qs_q[29:0], 2'b00};
        if (it_q == 6'd15) cos_q <= {1'b0, root_q[14:0], sub_ge};
      end
      ST_SOLID: begin
        if (ph_q) solid_q <= lasc_pkg::SolidW'((prod + 40'd32768) >> 16);
      end
      default: ;
    endcase
  end

  // output register
  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
      slot_o        <= r_slot_q;
      slot_valid_o  <= r_valid_q;
      on_out_o      <= r_on_q;
      half_size_o   <= r_half_q;
      cos_angle_o   <= cos_q;
      solid_angle_o <= solid_q;
      highest_on_o  <= r_high_q;
      last_out_o    <= r_last_q;
    end
  end

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("new item taken while busy");

  a_on_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && on_out_o |-> slot_valid_o) else $error("enable set on invalid slot");

  a_point_solid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cos_angle_o == lasc_pkg::CosOne |-> solid_angle_o == '0)
    else $error("point light with nonzero solid angle");

endmodule
